// ----- design/cslex_pkg.sv -----
`timescale 1ns / 1ps

package cslex_pkg;

    localparam int MAX_TEXT_DEF = 255;

    // Token codes
    localparam logic [5:0] TK_EOF      = 6'd0;
    localparam logic [5:0] TK_NAME     = 6'd1;
    localparam logic [5:0] TK_INT      = 6'd2;
    localparam logic [5:0] TK_STR      = 6'd3;
    localparam logic [5:0] TK_KW_INT   = 6'd4;
    localparam logic [5:0] TK_VOID     = 6'd5;
    localparam logic [5:0] TK_CHAR     = 6'd6;
    localparam logic [5:0] TK_KW_RET   = 6'd7;
    localparam logic [5:0] TK_IF       = 6'd8;
    localparam logic [5:0] TK_ELSE     = 6'd9;
    localparam logic [5:0] TK_KW_WHILE = 6'd10;
    localparam logic [5:0] TK_FOR      = 6'd11;
    localparam logic [5:0] TK_LPAREN   = 6'd12;
    localparam logic [5:0] TK_RPAREN   = 6'd13;
    localparam logic [5:0] TK_LBRACE   = 6'd14;
    localparam logic [5:0] TK_RBRACE   = 6'd15;
    localparam logic [5:0] TK_SEMI     = 6'd16;
    localparam logic [5:0] TK_SEP      = 6'd17;
    localparam logic [5:0] TK_ASGN     = 6'd18;
    localparam logic [5:0] TK_PLUS     = 6'd19;
    localparam logic [5:0] TK_SUB      = 6'd20;
    localparam logic [5:0] TK_STAR     = 6'd21;
    localparam logic [5:0] TK_DIV      = 6'd22;
    localparam logic [5:0] TK_PCT      = 6'd23;
    localparam logic [5:0] TK_EQ       = 6'd24;
    localparam logic [5:0] TK_NE       = 6'd25;
    localparam logic [5:0] TK_LT       = 6'd26;
    localparam logic [5:0] TK_LE       = 6'd27;
    localparam logic [5:0] TK_GT       = 6'd28;
    localparam logic [5:0] TK_GE       = 6'd29;
    localparam logic [5:0] TK_NOT      = 6'd30;
    localparam logic [5:0] TK_ANDAND   = 6'd31;
    localparam logic [5:0] TK_OROR     = 6'd32;

    localparam logic RK_TEXT  = 1'b0;
    localparam logic RK_TOKEN = 1'b1;

    typedef struct packed {
        logic        result_kind;
        logic [5:0]  token_kind;
        logic [31:0] int_value;
        logic [7:0]  text_byte;
        logic [15:0] line_number;
        logic        error;
    } result_t;

    // Up to three results caused by one source byte
    typedef struct packed {
        logic [1:0]       cnt;
        result_t [2:0]    res;
    } group_t;

endpackage

// ----- design/cslex_step.sv -----
`timescale 1ns / 1ps

module cslex_step #(
    parameter int MAX_TEXT = cslex_pkg::MAX_TEXT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,
    input  logic [7:0]          src_byte,
    input  logic                src_last,
    output cslex_pkg::group_t   group
);

    localparam logic [7:0] TEXT_LIM = 8'(MAX_TEXT);

    localparam logic [47:0] KW_IF     = 48'h6966;
    localparam logic [47:0] KW_INT    = 48'h696E74;
    localparam logic [47:0] KW_FOR    = 48'h666F72;
    localparam logic [47:0] KW_VOID   = 48'h766F6964;
    localparam logic [47:0] KW_CHAR   = 48'h63686172;
    localparam logic [47:0] KW_ELSE   = 48'h656C7365;
    localparam logic [47:0] KW_WHILE  = 48'h7768696C65;
    localparam logic [47:0] KW_RETURN = 48'h72657475726E;

    typedef enum logic [4:0] {
        M_IDLE, M_ID, M_NUM, M_STR, M_STR_ESC, M_CHR_OPEN, M_CHR_ESC, M_CHR_CLOSE,
        M_SLASH, M_LINE, M_BLK, M_BLK_STAR, M_P_EQ, M_P_NOT, M_P_LT, M_P_GT,
        M_P_AMP, M_P_BAR, M_DEAD
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [7:0]  text_count_reg, text_count_next;
    logic [31:0] number_accum_reg, number_accum_next;
    logic [47:0] keyword_prefix_reg, keyword_prefix_next;
    logic [15:0] line_count_reg, line_count_next;
    logic [7:0]  pending_char_reg, pending_char_next;

    cslex_pkg::result_t cand_res [4];
    logic               cand_vld [4];
    logic               relex;
    logic               finish;
    logic [1:0]         fill;

    function automatic logic is_word_lead(input logic [7:0] c);
        // letters and underscore
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h6E:   r = 8'h0A;  // n
            8'h74:   r = 8'h09;  // t
            8'h72:   r = 8'h0D;  // r
            8'h30:   r = 8'h00;  // 0
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] word_kind(input logic [7:0] tc, input logic [47:0] p);
        logic [5:0] k;
        k = cslex_pkg::TK_NAME;
        case (tc)
            8'd2: if (p == KW_IF) k = cslex_pkg::TK_IF;
            8'd3: begin
                if (p == KW_INT) k = cslex_pkg::TK_KW_INT;
                if (p == KW_FOR) k = cslex_pkg::TK_FOR;
            end
            8'd4: begin
                if (p == KW_VOID) k = cslex_pkg::TK_VOID;
                if (p == KW_CHAR) k = cslex_pkg::TK_CHAR;
                if (p == KW_ELSE) k = cslex_pkg::TK_ELSE;
            end
            8'd5: if (p == KW_WHILE) k = cslex_pkg::TK_KW_WHILE;
            8'd6: if (p == KW_RETURN) k = cslex_pkg::TK_KW_RET;
            default: k = cslex_pkg::TK_NAME;
        endcase
        return k;
    endfunction

    function automatic cslex_pkg::result_t mk_res(
        input logic kind, input logic [5:0] tok, input logic [31:0] val,
        input logic [7:0] txt, input logic [15:0] ln, input logic err);
        cslex_pkg::result_t r;
        r.result_kind = kind;
        r.token_kind  = tok;
        r.int_value   = val;
        r.text_byte   = txt;
        r.line_number = ln;
        r.error       = err;
        return r;
    endfunction

    function automatic cslex_pkg::result_t mk_tok(input logic [5:0] tok, input logic [15:0] ln);
        return mk_res(cslex_pkg::RK_TOKEN, tok, 32'd0, 8'd0, ln, 1'b0);
    endfunction

    always_comb begin
        mode_next           = mode_reg;
        text_count_next     = text_count_reg;
        number_accum_next   = number_accum_reg;
        keyword_prefix_next = keyword_prefix_reg;
        line_count_next     = line_count_reg;
        pending_char_next   = pending_char_reg;
        relex               = 1'b0;
        finish              = (src_byte == 8'd0) || src_last;
        for (int i = 0; i < 4; i++) begin
            cand_res[i] = '0;
            cand_vld[i] = 1'b0;
        end

        // First pass: continue the open token
        if (src_byte != 8'd0) begin
            unique case (mode_reg)
                M_ID: begin
                    if ((is_word_lead(src_byte) || is_digit(src_byte))
                        && text_count_reg < TEXT_LIM) begin
                        cand_res[0] = mk_res(cslex_pkg::RK_TEXT, cslex_pkg::TK_EOF, 32'd0,
                                             pending_char_reg, line_count_next, 1'b0);
                        cand_vld[0] = 1'b1;
                        pending_char_next   = src_byte;
                        text_count_next     = text_count_reg + 8'd1;
                        keyword_prefix_next = {keyword_prefix_reg[39:0], src_byte};
                    end else begin
                        cand_res[0] = mk_res(cslex_pkg::RK_TOKEN,
                                             word_kind(text_count_reg, keyword_prefix_reg),
                                             32'd0, pending_char_reg, line_count_next, 1'b0);
                        cand_vld[0] = 1'b1;
                        mode_next   = M_IDLE;
                        relex       = 1'b1;
                    end
                end
                M_NUM: begin
                    if (is_digit(src_byte)) begin
                        number_accum_next = {number_accum_reg[28:0], 3'b000}
                                          + {number_accum_reg[30:0], 1'b0}
                                          + {24'd0, src_byte - 8'h30};
                    end else begin
                        cand_res[0] = mk_res(cslex_pkg::RK_TOKEN, cslex_pkg::TK_INT,
                                             number_accum_reg, 8'd0, line_count_next, 1'b0);
                        cand_vld[0] = 1'b1;
                        mode_next   = M_IDLE;
                        relex       = 1'b1;
                    end
                end
                M_STR: begin
                    if (src_byte == 8'h22) begin
                        cand_res[0] = mk_tok(cslex_pkg::TK_STR, line_count_next);
                        cand_vld[0] = 1'b1;
                        mode_next   = M_IDLE;
                    end else if (src_byte == 8'h5C) begin
                        mode_next = M_STR_ESC;
                    end else if (text_count_reg < TEXT_LIM) begin
                        cand_res[0] = mk_res(cslex_pkg::RK_TEXT, cslex_pkg::TK_EOF, 32'd0,
                                             src_byte, line_count_next, 1'b0);
                        cand_vld[0]     = 1'b1;
                        text_count_next = text_count_reg + 8'd1;
                    end
                end
                M_STR_ESC: begin
                    if (text_count_reg < TEXT_LIM) begin
                        cand_res[0] = mk_res(cslex_pkg::RK_TEXT, cslex_pkg::TK_EOF, 32'd0,
                                             esc_map(src_byte), line_count_next, 1'b0);
                        cand_vld[0]     = 1'b1;
                        text_count_next = text_count_reg + 8'd1;
                    end
                    mode_next = M_STR;
                end
                M_CHR_OPEN: begin
                    if (src_byte == 8'h5C) begin
                        mode_next = M_CHR_ESC;
                    end else begin
                        number_accum_next = {24'd0, src_byte};
                        mode_next         = M_CHR_CLOSE;
                    end
                end
                M_CHR_ESC: begin
                    number_accum_next = {24'd0, esc_map(src_byte)};
                    mode_next         = M_CHR_CLOSE;
                end
                M_CHR_CLOSE: begin
                    cand_res[0] = mk_res(cslex_pkg::RK_TOKEN, cslex_pkg::TK_INT,
                                         number_accum_reg, 8'd0, line_count_next, 1'b0);
                    cand_vld[0] = 1'b1;
                    mode_next   = M_IDLE;
                    // closing quote is optional; anything else is lexed again
                    relex       = (src_byte != 8'h27);
                end
                M_SLASH: begin
                    if (src_byte == 8'h2F) begin
                        mode_next = M_LINE;
                    end else if (src_byte == 8'h2A) begin
                        mode_next = M_BLK;
                    end else begin
                        cand_res[0] = mk_tok(cslex_pkg::TK_DIV, line_count_next);
                        cand_vld[0] = 1'b1;
                        mode_next   = M_IDLE;
                        relex       = 1'b1;
                    end
                end
                M_LINE: begin
                    if (src_byte == 8'h0A) begin
                        if (line_count_next != 16'hFFFF) line_count_next = line_count_next + 16'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_BLK, M_BLK_STAR: begin
                    if (mode_reg == M_BLK_STAR && src_byte == 8'h2F) begin
                        mode_next = M_IDLE;
                    end else begin
                        if (src_byte == 8'h0A && line_count_next != 16'hFFFF) begin
                            line_count_next = line_count_next + 16'd1;
                        end
                        mode_next = (src_byte == 8'h2A) ? M_BLK_STAR : M_BLK;
                    end
                end
                M_P_EQ, M_P_NOT, M_P_LT, M_P_GT: begin
                    mode_next   = M_IDLE;
                    cand_vld[0] = 1'b1;
                    if (src_byte == 8'h3D) begin
                        cand_res[0] = mk_tok(mode_reg == M_P_EQ  ? cslex_pkg::TK_EQ :
                                             mode_reg == M_P_NOT ? cslex_pkg::TK_NE :
                                             mode_reg == M_P_LT  ? cslex_pkg::TK_LE :
                                                                   cslex_pkg::TK_GE,
                                             line_count_next);
                    end else begin
                        cand_res[0] = mk_tok(mode_reg == M_P_EQ  ? cslex_pkg::TK_ASGN :
                                             mode_reg == M_P_NOT ? cslex_pkg::TK_NOT :
                                             mode_reg == M_P_LT  ? cslex_pkg::TK_LT :
                                                                   cslex_pkg::TK_GT,
                                             line_count_next);
                        relex = 1'b1;
                    end
                end
                M_P_AMP, M_P_BAR: begin
                    cand_vld[0] = 1'b1;
                    if (mode_reg == M_P_AMP && src_byte == 8'h26) begin
                        cand_res[0] = mk_tok(cslex_pkg::TK_ANDAND, line_count_next);
                        mode_next   = M_IDLE;
                    end else if (mode_reg == M_P_BAR && src_byte == 8'h7C) begin
                        cand_res[0] = mk_tok(cslex_pkg::TK_OROR, line_count_next);
                        mode_next   = M_IDLE;
                    end else begin
                        cand_res[0] = mk_res(cslex_pkg::RK_TOKEN, cslex_pkg::TK_EOF, 32'd0,
                                             8'd0, line_count_next, 1'b1);
                        mode_next   = M_DEAD;
                    end
                end
                M_DEAD: ;
                default: relex = 1'b1;  // idle: start a new token below
            endcase
        end

        // Second pass: start a new token on this byte
        if (relex) begin
            mode_next = M_IDLE;
            case (src_byte) inside
                8'h20, 8'h09, 8'h0D: ;
                8'h0A: if (line_count_next != 16'hFFFF) line_count_next = line_count_next + 16'd1;
                8'h23: mode_next = M_LINE;
                8'h2F: mode_next = M_SLASH;
                8'h22: begin
                    mode_next       = M_STR;
                    text_count_next = 8'd0;
                end
                8'h27: begin
                    mode_next         = M_CHR_OPEN;
                    number_accum_next = 32'd0;
                end
                8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3B, 8'h2C, 8'h2B, 8'h2D, 8'h2A, 8'h25: begin
                    cand_vld[1] = 1'b1;
                    case (src_byte)
                        8'h28:   cand_res[1] = mk_tok(cslex_pkg::TK_LPAREN, line_count_next);
                        8'h29:   cand_res[1] = mk_tok(cslex_pkg::TK_RPAREN, line_count_next);
                        8'h7B:   cand_res[1] = mk_tok(cslex_pkg::TK_LBRACE, line_count_next);
                        8'h7D:   cand_res[1] = mk_tok(cslex_pkg::TK_RBRACE, line_count_next);
                        8'h3B:   cand_res[1] = mk_tok(cslex_pkg::TK_SEMI, line_count_next);
                        8'h2C:   cand_res[1] = mk_tok(cslex_pkg::TK_SEP, line_count_next);
                        8'h2B:   cand_res[1] = mk_tok(cslex_pkg::TK_PLUS, line_count_next);
                        8'h2D:   cand_res[1] = mk_tok(cslex_pkg::TK_SUB, line_count_next);
                        8'h2A:   cand_res[1] = mk_tok(cslex_pkg::TK_STAR, line_count_next);
                        default: cand_res[1] = mk_tok(cslex_pkg::TK_PCT, line_count_next);
                    endcase
                end
                8'h3D: mode_next = M_P_EQ;
                8'h21: mode_next = M_P_NOT;
                8'h3C: mode_next = M_P_LT;
                8'h3E: mode_next = M_P_GT;
                8'h26: mode_next = M_P_AMP;
                8'h7C: mode_next = M_P_BAR;
                default: begin
                    if (is_word_lead(src_byte)) begin
                        mode_next           = M_ID;
                        text_count_next     = 8'd1;
                        pending_char_next   = src_byte;
                        keyword_prefix_next = {40'd0, src_byte};
                    end else if (is_digit(src_byte)) begin
                        mode_next         = M_NUM;
                        number_accum_next = {24'd0, src_byte - 8'h30};
                    end else begin
                        cand_res[1] = mk_res(cslex_pkg::RK_TOKEN, cslex_pkg::TK_EOF, 32'd0,
                                             8'd0, line_count_next, 1'b1);
                        cand_vld[1] = 1'b1;
                        mode_next   = M_DEAD;
                    end
                end
            endcase
        end

        // End of source: flush the open token, then EOF, then back to reset
        if (finish) begin
            cand_vld[2] = 1'b1;
            unique case (mode_next)
                M_ID: cand_res[2] = mk_res(cslex_pkg::RK_TOKEN,
                                           word_kind(text_count_next, keyword_prefix_next),
                                           32'd0, pending_char_next, line_count_next, 1'b0);
                M_NUM, M_CHR_CLOSE:
                    cand_res[2] = mk_res(cslex_pkg::RK_TOKEN, cslex_pkg::TK_INT,
                                         number_accum_next, 8'd0, line_count_next, 1'b0);
                M_STR, M_STR_ESC: cand_res[2] = mk_tok(cslex_pkg::TK_STR, line_count_next);
                M_CHR_OPEN, M_CHR_ESC: cand_res[2] = mk_tok(cslex_pkg::TK_INT, line_count_next);
                M_SLASH: cand_res[2] = mk_tok(cslex_pkg::TK_DIV, line_count_next);
                M_P_EQ:  cand_res[2] = mk_tok(cslex_pkg::TK_ASGN, line_count_next);
                M_P_NOT: cand_res[2] = mk_tok(cslex_pkg::TK_NOT, line_count_next);
                M_P_LT:  cand_res[2] = mk_tok(cslex_pkg::TK_LT, line_count_next);
                M_P_GT:  cand_res[2] = mk_tok(cslex_pkg::TK_GT, line_count_next);
                M_P_AMP, M_P_BAR:
                    cand_res[2] = mk_res(cslex_pkg::RK_TOKEN, cslex_pkg::TK_EOF, 32'd0,
                                         8'd0, line_count_next, 1'b1);
                default: cand_vld[2] = 1'b0;
            endcase
            cand_res[3] = mk_tok(cslex_pkg::TK_EOF, line_count_next);
            cand_vld[3] = 1'b1;

            mode_next           = M_IDLE;
            text_count_next     = 8'd0;
            number_accum_next   = 32'd0;
            keyword_prefix_next = 48'd0;
            line_count_next     = 16'd1;
            pending_char_next   = 8'd0;
        end
    end

    // Pack the first three results; any beyond that are dropped
    always_comb begin
        group = '0;
        fill  = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (cand_vld[i] && fill != 2'd3) begin
                group.res[fill] = cand_res[i];
                fill            = fill + 2'd1;
            end
        end
        group.cnt = fill;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg           <= M_IDLE;
            text_count_reg     <= 8'd0;
            number_accum_reg   <= 32'd0;
            keyword_prefix_reg <= 48'd0;
            line_count_reg     <= 16'd1;
            pending_char_reg   <= 8'd0;
        end else if (take) begin
            mode_reg           <= mode_next;
            text_count_reg     <= text_count_next;
            number_accum_reg   <= number_accum_next;
            keyword_prefix_reg <= keyword_prefix_next;
            line_count_reg     <= line_count_next;
            pending_char_reg   <= pending_char_next;
        end
    end

endmodule

// ----- design/cslex_outq.sv -----
`timescale 1ns / 1ps

module cslex_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  cslex_pkg::group_t   group,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output cslex_pkg::result_t  head,
    output logic                head_is_final
);

    logic [1:0]         cnt_reg, cnt_next;
    cslex_pkg::result_t res_reg [3];

    assign m_valid       = (cnt_reg != 2'd0);
    assign can_load      = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign head          = res_reg[0];
    assign head_is_final = (cnt_reg == 2'd1);

    always_comb begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = group.cnt;
        end else if (m_valid && m_ready) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Load a fresh group, or advance the remaining words toward the head
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg[0] <= group.res[0];
            res_reg[1] <= group.res[1];
            res_reg[2] <= group.res[2];
        end else if (m_valid && m_ready) begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

endmodule

// ----- design/c_subset_lexer.sv -----
`timescale 1ns / 1ps

// Byte-serial scanner for a small C subset. Source bytes enter on the s_ channel; tokens
// and identifier/string text bytes leave on the m_ channel, one word per cycle while
// m_ready is high. A byte is held in an input register, lexed combinationally, and its
// results (zero to three) are loaded into a three-entry output register that drains one
// word per cycle while m_ready is high. If each byte causes at most one result, the input
// runs at one byte per clock while m_ready is high; a byte that causes two or three
// results holds the input while the output register drains. m_run_end marks the last
// word caused by one source byte. A zero byte or s_last ends the source: the open token
// and then EOF are sent and the scanner returns to reset.

module c_subset_lexer #(
    parameter int MAX_TEXT = cslex_pkg::MAX_TEXT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_src_byte,
    input  logic               s_last,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_result_kind,
    output logic [5:0]         m_token_kind,
    output logic signed [31:0] m_int_value,
    output logic [7:0]         m_text_byte,
    output logic [15:0]        m_line_number,
    output logic               m_error,
    output logic               m_run_end
);

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;
    logic               take;
    logic               can_load;
    cslex_pkg::group_t  group;
    cslex_pkg::result_t head;
    logic               head_is_final;

    assign take          = in_valid_reg && can_load;
    assign s_ready       = !in_valid_reg || take;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_src_byte;
            in_last_reg <= s_last;
        end
    end

    cslex_step #(
        .MAX_TEXT (MAX_TEXT)
    ) u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .src_byte (in_byte_reg),
        .src_last (in_last_reg),
        .group    (group)
    );

    cslex_outq u_outq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (take),
        .group         (group),
        .can_load      (can_load),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .head          (head),
        .head_is_final (head_is_final)
    );

    assign m_result_kind = head.result_kind;
    assign m_token_kind  = head.token_kind;
    assign m_int_value   = $signed(head.int_value);
    assign m_text_byte   = head.text_byte;
    assign m_line_number = head.line_number;
    assign m_error       = head.error;
    assign m_run_end     = head_is_final;

endmodule

// ----- tb/c_subset_lexer_test.sv -----
`timescale 1ns / 1ps

module c_subset_lexer_test;

    localparam int MAX_TEXT = cslex_pkg::MAX_TEXT_DEF;
    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASE_BYTES = 70;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    typedef enum logic [4:0] {
        SM_IDLE, SM_ID, SM_NUM, SM_STR, SM_STR_ESC, SM_CHR_OPEN, SM_CHR_ESC,
        SM_CHR_CLOSE, SM_SLASH, SM_LINE, SM_BLK, SM_BLK_STAR, SM_P_EQ, SM_P_NOT,
        SM_P_LT, SM_P_GT, SM_P_AMP, SM_P_BAR, SM_DEAD
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } src_item_t;

    typedef struct packed {
        cslex_pkg::result_t res;
        logic               run_end;
    } word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_src_byte = 8'd0;
    logic s_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_result_kind;
    logic [5:0] m_token_kind;
    logic signed [31:0] m_int_value;
    logic [7:0] m_text_byte;
    logic [15:0] m_line_number;
    logic m_error;
    logic m_run_end;

    c_subset_lexer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_src_byte(s_src_byte), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_kind(m_result_kind),
        .m_token_kind(m_token_kind), .m_int_value(m_int_value), .m_text_byte(m_text_byte),
        .m_line_number(m_line_number), .m_error(m_error), .m_run_end(m_run_end)
    );

    src_item_t src_queue[$];
    word_t words_due[$];
    bit byte_taken = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned holdoff_gen = 0;
    int unsigned bytes_queued = 0;
    int unsigned sources_queued = 0;
    int unsigned bytes_lexed = 0;
    int unsigned words_checked = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    // Scanner state mirrored by the predictor
    scan_mode_t mode = SM_IDLE;
    int txt_cnt = 0;
    logic [31:0] num_acc = '0;
    logic [47:0] kw_tail = '0;
    logic [15:0] line_no = 16'd1;
    logic [7:0] held_char = '0;
    word_t step_buf[3];
    int step_n;

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic bit is_word_start(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_dec(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [7:0] unescape(logic [7:0] c);
        case (c)
            "n": return CH_LF;
            "t": return CH_TAB;
            "r": return CH_CR;
            "0": return 8'd0;
            default: return c;
        endcase
    endfunction

    function automatic logic [5:0] word_token();
        case (txt_cnt)
            2: if (kw_tail == 48'("if")) return cslex_pkg::TK_IF;
            3: begin
                if (kw_tail == 48'("int")) return cslex_pkg::TK_KW_INT;
                if (kw_tail == 48'("for")) return cslex_pkg::TK_FOR;
            end
            4: begin
                if (kw_tail == 48'("void")) return cslex_pkg::TK_VOID;
                if (kw_tail == 48'("char")) return cslex_pkg::TK_CHAR;
                if (kw_tail == 48'("else")) return cslex_pkg::TK_ELSE;
            end
            5: if (kw_tail == 48'("while")) return cslex_pkg::TK_KW_WHILE;
            6: if (kw_tail == 48'("return")) return cslex_pkg::TK_KW_RET;
            default: ;
        endcase
        return cslex_pkg::TK_NAME;
    endfunction

    task automatic queue_word(input logic kind, input logic [5:0] tok, input logic [31:0] val,
                              input logic [7:0] txt, input logic err);
        if (step_n < 3) begin
            step_buf[step_n].res.result_kind = kind;
            step_buf[step_n].res.token_kind = tok;
            step_buf[step_n].res.int_value = val;
            step_buf[step_n].res.text_byte = txt;
            step_buf[step_n].res.line_number = line_no;
            step_buf[step_n].res.error = err;
            step_buf[step_n].run_end = 1'b0;
            step_n++;
        end
    endtask

    task automatic queue_token(input logic [5:0] tok);
        queue_word(cslex_pkg::RK_TOKEN, tok, 32'd0, 8'd0, 1'b0);
    endtask

    task automatic bump_line();
        if (line_no != 16'hFFFF) line_no++;
    endtask

    task automatic clear_scan();
        mode = SM_IDLE;
        txt_cnt = 0;
        num_acc = '0;
        kw_tail = '0;
        line_no = 16'd1;
        held_char = '0;
    endtask

    task automatic start_token(input logic [7:0] c);
        mode = SM_IDLE;
        case (c)
            " ", CH_TAB, CH_CR: ;
            CH_LF: bump_line();
            "#": mode = SM_LINE;
            "/": mode = SM_SLASH;
            "\"": begin
                mode = SM_STR;
                txt_cnt = 0;
            end
            "'": begin
                mode = SM_CHR_OPEN;
                num_acc = '0;
            end
            "(": queue_token(cslex_pkg::TK_LPAREN);
            ")": queue_token(cslex_pkg::TK_RPAREN);
            "{": queue_token(cslex_pkg::TK_LBRACE);
            "}": queue_token(cslex_pkg::TK_RBRACE);
            ";": queue_token(cslex_pkg::TK_SEMI);
            ",": queue_token(cslex_pkg::TK_SEP);
            "+": queue_token(cslex_pkg::TK_PLUS);
            "-": queue_token(cslex_pkg::TK_SUB);
            "*": queue_token(cslex_pkg::TK_STAR);
            "%": queue_token(cslex_pkg::TK_PCT);
            "=": mode = SM_P_EQ;
            "!": mode = SM_P_NOT;
            "<": mode = SM_P_LT;
            ">": mode = SM_P_GT;
            "&": mode = SM_P_AMP;
            "|": mode = SM_P_BAR;
            default: begin
                if (is_word_start(c)) begin
                    mode = SM_ID;
                    txt_cnt = 1;
                    held_char = c;
                    kw_tail = {40'd0, c};
                end else if (is_dec(c)) begin
                    mode = SM_NUM;
                    num_acc = {24'd0, c - 8'd48};
                end else begin
                    queue_word(cslex_pkg::RK_TOKEN, cslex_pkg::TK_EOF, 32'd0, 8'd0, 1'b1);
                    mode = SM_DEAD;
                end
            end
        endcase
    endtask

    // used = 0 means the byte closed a token and must be scanned again
    task automatic lex_consume(input logic [7:0] c, output bit used);
        logic [5:0] one_tok;
        logic [5:0] two_tok;
        used = 1'b1;
        case (mode)
            SM_ID: begin
                if ((is_word_start(c) || is_dec(c)) && txt_cnt < MAX_TEXT) begin
                    queue_word(cslex_pkg::RK_TEXT, cslex_pkg::TK_EOF, 32'd0, held_char, 1'b0);
                    held_char = c;
                    txt_cnt++;
                    kw_tail = {kw_tail[39:0], c};
                end else begin
                    queue_word(cslex_pkg::RK_TOKEN, word_token(), 32'd0, held_char, 1'b0);
                    mode = SM_IDLE;
                    used = 1'b0;
                end
            end
            SM_NUM: begin
                if (is_dec(c)) begin
                    num_acc = num_acc * 32'd10 + {24'd0, c - 8'd48};
                end else begin
                    queue_word(cslex_pkg::RK_TOKEN, cslex_pkg::TK_INT, num_acc, 8'd0, 1'b0);
                    mode = SM_IDLE;
                    used = 1'b0;
                end
            end
            SM_STR: begin
                if (c == "\"") begin
                    queue_token(cslex_pkg::TK_STR);
                    mode = SM_IDLE;
                end else if (c == "\\") begin
                    mode = SM_STR_ESC;
                end else if (txt_cnt < MAX_TEXT) begin
                    queue_word(cslex_pkg::RK_TEXT, cslex_pkg::TK_EOF, 32'd0, c, 1'b0);
                    txt_cnt++;
                end
            end
            SM_STR_ESC: begin
                if (txt_cnt < MAX_TEXT) begin
                    queue_word(cslex_pkg::RK_TEXT, cslex_pkg::TK_EOF, 32'd0, unescape(c),
                               1'b0);
                    txt_cnt++;
                end
                mode = SM_STR;
            end
            SM_CHR_OPEN: begin
                if (c == "\\") begin
                    mode = SM_CHR_ESC;
                end else begin
                    num_acc = {24'd0, c};
                    mode = SM_CHR_CLOSE;
                end
            end
            SM_CHR_ESC: begin
                num_acc = {24'd0, unescape(c)};
                mode = SM_CHR_CLOSE;
            end
            SM_CHR_CLOSE: begin
                queue_word(cslex_pkg::RK_TOKEN, cslex_pkg::TK_INT, num_acc, 8'd0, 1'b0);
                mode = SM_IDLE;
                used = (c == "'");
            end
            SM_SLASH: begin
                if (c == "/") begin
                    mode = SM_LINE;
                end else if (c == "*") begin
                    mode = SM_BLK;
                end else begin
                    queue_token(cslex_pkg::TK_DIV);
                    mode = SM_IDLE;
                    used = 1'b0;
                end
            end
            SM_LINE: begin
                if (c == CH_LF) begin
                    bump_line();
                    mode = SM_IDLE;
                end
            end
            SM_BLK, SM_BLK_STAR: begin
                if (mode == SM_BLK_STAR && c == "/") begin
                    mode = SM_IDLE;
                end else begin
                    if (c == CH_LF) bump_line();
                    mode = (c == "*") ? SM_BLK_STAR : SM_BLK;
                end
            end
            SM_P_EQ, SM_P_NOT, SM_P_LT, SM_P_GT: begin
                case (mode)
                    SM_P_EQ: begin
                        one_tok = cslex_pkg::TK_ASGN;
                        two_tok = cslex_pkg::TK_EQ;
                    end
                    SM_P_NOT: begin
                        one_tok = cslex_pkg::TK_NOT;
                        two_tok = cslex_pkg::TK_NE;
                    end
                    SM_P_LT: begin
                        one_tok = cslex_pkg::TK_LT;
                        two_tok = cslex_pkg::TK_LE;
                    end
                    default: begin
                        one_tok = cslex_pkg::TK_GT;
                        two_tok = cslex_pkg::TK_GE;
                    end
                endcase
                mode = SM_IDLE;
                if (c == "=") begin
                    queue_token(two_tok);
                end else begin
                    queue_token(one_tok);
                    used = 1'b0;
                end
            end
            SM_P_AMP, SM_P_BAR: begin
                if (mode == SM_P_AMP && c == "&") begin
                    queue_token(cslex_pkg::TK_ANDAND);
                    mode = SM_IDLE;
                end else if (mode == SM_P_BAR && c == "|") begin
                    queue_token(cslex_pkg::TK_OROR);
                    mode = SM_IDLE;
                end else begin
                    queue_word(cslex_pkg::RK_TOKEN, cslex_pkg::TK_EOF, 32'd0, 8'd0, 1'b1);
                    mode = SM_DEAD;
                end
            end
            SM_DEAD: ;
            default: start_token(c);
        endcase
    endtask

    task automatic close_source();
        case (mode)
            SM_ID: queue_word(cslex_pkg::RK_TOKEN, word_token(), 32'd0, held_char, 1'b0);
            SM_NUM, SM_CHR_CLOSE:
                queue_word(cslex_pkg::RK_TOKEN, cslex_pkg::TK_INT, num_acc, 8'd0, 1'b0);
            SM_STR, SM_STR_ESC: queue_token(cslex_pkg::TK_STR);
            SM_CHR_OPEN, SM_CHR_ESC: queue_token(cslex_pkg::TK_INT);
            SM_SLASH: queue_token(cslex_pkg::TK_DIV);
            SM_P_EQ: queue_token(cslex_pkg::TK_ASGN);
            SM_P_NOT: queue_token(cslex_pkg::TK_NOT);
            SM_P_LT: queue_token(cslex_pkg::TK_LT);
            SM_P_GT: queue_token(cslex_pkg::TK_GT);
            SM_P_AMP, SM_P_BAR:
                queue_word(cslex_pkg::RK_TOKEN, cslex_pkg::TK_EOF, 32'd0, 8'd0, 1'b1);
            default: ;
        endcase
        queue_token(cslex_pkg::TK_EOF);
        clear_scan();
    endtask

    task automatic lex_byte(input logic [7:0] c, input logic last);
        bit used;
        step_n = 0;
        if (c == 8'd0) begin
            close_source();
        end else begin
            lex_consume(c, used);
            if (!used) lex_consume(c, used);
            if (last) close_source();
        end
        if (step_n > 0) step_buf[step_n - 1].run_end = 1'b1;
        for (int i = 0; i < step_n; i++) words_due.push_back(step_buf[i]);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: predict on each accepted byte, then score each accepted word
    always @(posedge aclk) begin
        word_t exp_word;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still due", cycle_count,
                     words_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (aresetn) begin
            if (s_valid && s_ready) begin
                lex_byte(s_src_byte, s_last);
                bytes_lexed++;
            end
            if (m_valid && m_ready) begin
                words_checked++;
                if (words_due.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual kind %0h token %0d",
                             $time, m_result_kind, m_token_kind);
                    mismatches++;
                end else begin
                    exp_word = words_due.pop_front();
                    check_field("result_kind", 32'(exp_word.res.result_kind),
                                32'(m_result_kind));
                    check_field("token_kind", 32'(exp_word.res.token_kind), 32'(m_token_kind));
                    check_field("int_value", exp_word.res.int_value, m_int_value);
                    check_field("text_byte", 32'(exp_word.res.text_byte), 32'(m_text_byte));
                    check_field("line_number", 32'(exp_word.res.line_number),
                                32'(m_line_number));
                    check_field("error", 32'(exp_word.res.error), 32'(m_error));
                    check_field("run_end", 32'(exp_word.run_end), 32'(m_run_end));
                end
            end
        end
        byte_taken <= aresetn && s_valid && s_ready;
    end

    // Driver: advance to the next byte once the current byte is taken
    always @(negedge aclk) begin
        src_item_t item;
        if (aresetn && (!s_valid || byte_taken)) begin
            if (src_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                item = src_queue.pop_front();
                s_valid <= 1'b1;
                s_src_byte <= item.ch;
                s_last <= item.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        static int unsigned holdoff_seen = 0;
        static int hold_left = 0;
        if (holdoff_gen != holdoff_seen) begin
            holdoff_seen = holdoff_gen;
            hold_left = HOLDOFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_byte(input logic [7:0] c, input logic last);
        src_item_t item;
        item.ch = c;
        item.last = last;
        src_queue.push_back(item);
        bytes_queued++;
        if (last || c == 8'd0) sources_queued++;
    endtask

    task automatic push_text(input string s, input bit end_source);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], end_source && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] rand_word_char(input bit first);
        string pool;
        pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        return pool[$urandom_range(first ? 52 : 62, 0)];
    endfunction

    // Any nonzero byte that neither closes a string nor starts an escape
    function automatic logic [7:0] rand_str_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(255, 1)); while (c == "\"" || c == "\\");
        return c;
    endfunction

    function automatic logic [7:0] rand_escape();
        string pool;
        pool = "ntr0";
        if ($urandom_range(1)) return pool[$urandom_range(3)];
        return 8'($urandom_range(255, 1));
    endfunction

    task automatic build_program(input int lexemes);
        string kws[8] = '{"int", "void", "char", "return", "if", "else", "while", "for"};
        string ops[21] = '{"(", ")", "{", "}", ";", ",", "=", "+", "-", "*", "/", "%",
                           "==", "!=", "<", "<=", ">", ">=", "!", "&&", "||"};
        string cuts[14] = '{"\"ab", "'", "'\\", "/*x", "//", "=", "!", "<", ">", "&", "|",
                            "\"\\", "12", "'a"};
        string pool;
        logic [7:0] c;
        int len;
        for (int k = 0; k < lexemes; k++) begin
            case ($urandom_range(19))
                0, 1, 2: push_text(kws[$urandom_range(7)], 1'b0);
                3, 4, 5: begin
                    if ($urandom_range(3) == 0) begin
                        push_text(kws[$urandom_range(7)], 1'b0);
                        push_byte(rand_word_char(1'b0), 1'b0);
                    end else begin
                        len = $urandom_range(9, 1);
                        for (int i = 0; i < len; i++) push_byte(rand_word_char(i == 0), 1'b0);
                    end
                end
                6, 7: begin
                    len = $urandom_range(12, 1);
                    for (int i = 0; i < len; i++)
                        push_byte(8'($urandom_range("9", "0")), 1'b0);
                end
                8: begin
                    push_byte("\"", 1'b0);
                    len = $urandom_range(10);
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(9) == 0) begin
                            push_byte("\\", 1'b0);
                            push_byte(rand_escape(), 1'b0);
                        end else begin
                            push_byte(rand_str_byte(), 1'b0);
                        end
                    end
                    push_byte("\"", 1'b0);
                end
                9: begin
                    push_byte("'", 1'b0);
                    if ($urandom_range(2) == 0) begin
                        push_byte("\\", 1'b0);
                        push_byte(rand_escape(), 1'b0);
                    end else begin
                        push_byte(8'($urandom_range(255, 1)), 1'b0);
                    end
                    if ($urandom_range(4) != 0) push_byte("'", 1'b0);
                end
                10, 11, 12, 13: push_text(ops[$urandom_range(20)], 1'b0);
                14: begin
                    if ($urandom_range(1)) push_text("//", 1'b0);
                    else push_byte("#", 1'b0);
                    len = $urandom_range(6);
                    for (int i = 0; i < len; i++) begin
                        do c = 8'($urandom_range(255, 1)); while (c == CH_LF);
                        push_byte(c, 1'b0);
                    end
                    push_byte(CH_LF, 1'b0);
                end
                15: begin
                    pool = "ab */\n";
                    push_text("/*", 1'b0);
                    len = $urandom_range(8);
                    for (int i = 0; i < len; i++) push_byte(pool[$urandom_range(5)], 1'b0);
                    push_text("*/", 1'b0);
                end
                16: begin
                    pool = " \t\r\n";
                    len = $urandom_range(3, 1);
                    for (int i = 0; i < len; i++) push_byte(pool[$urandom_range(3)], 1'b0);
                end
                17: push_byte(8'($urandom_range(255, 1)), 1'b0);
                default: push_byte(" ", 1'b0);
            endcase
            if ($urandom_range(1)) push_byte(($urandom_range(3) == 0) ? CH_LF : " ", 1'b0);
        end
        // Leave a token open at the end now and then
        if ($urandom_range(4) == 0) push_text(cuts[$urandom_range(13)], 1'b0);
        case ($urandom_range(9))
            0: push_byte(8'd0, 1'b1);
            1, 2, 3: push_byte(8'd0, 1'b0);
            default: begin
                if (src_queue.size() == 0 || src_queue[src_queue.size() - 1].last) begin
                    push_byte(";", 1'b1);
                end else begin
                    c = src_queue[src_queue.size() - 1].ch;
                    void'(src_queue.pop_back());
                    bytes_queued--;
                    push_byte(c, 1'b1);
                end
            end
        endcase
    endtask

    task automatic wait_drained();
        while (src_queue.size() != 0 || s_valid || words_due.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        int unsigned phase_start;
        int unsigned send_pcts[4] = '{0, 56, 0, 8};
        int unsigned recv_pcts[4] = '{0, 0, 56, 8};

        // Short sources that hit end-of-source and error corners
        push_text("x", 1'b1);
        push_byte(8'd0, 1'b0);
        push_text("a=", 1'b1);
        push_text("'\\", 1'b1);
        push_text("\"\\t\\", 1'b1);
        push_text("c!=&x", 1'b0);
        push_byte(8'd0, 1'b0);
        push_text("'\n'", 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'd0, 1'b1);
        push_text("|y&&z||", 1'b1);

        // Number that wraps past 32 bits
        push_text("99999999999999999999;", 1'b1);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            send_idle_pct = send_pcts[ph];
            recv_stall_pct = recv_pcts[ph];
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < PHASE_BYTES)
                build_program($urandom_range(12, 1));
            // Fill the block while the receiver holds off
            if (ph == 0) holdoff_gen++;
        end
        wait_drained();
        repeat (8) @(negedge aclk);

        if (words_due.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, words_due.size());
            mismatches += words_due.size();
        end
        $display("Lexed %0d bytes in %0d sources, %0d result words checked", bytes_lexed,
                 sources_queued, words_checked);
        $display("Flow control: free running, sender gaps, receiver stalls, both, hold-off");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/cslex_pkg.sv
design/cslex_step.sv
design/cslex_outq.sv
design/c_subset_lexer.sv
tb/c_subset_lexer_test.sv
